### hw/rtl/length_prefixed_message_fifo_core_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define LPMF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LPMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lpmf_pkg.sv
package lpmf_pkg;

   // Default geometry of the byte ring.
   localparam int DEFAULT_DEPTH        = 64;
   localparam int DEFAULT_HEADER_BYTES = 8;

   // Longest payload a read will deliver.
   localparam logic [5:0] MAX_PAYLOAD = 6'd55;

   // Operation codes.
   localparam logic [1:0] OP_WRITE_BEGIN = 2'd0;
   localparam logic [1:0] OP_WRITE_BYTE  = 2'd1;
   localparam logic [1:0] OP_READ        = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_TOO_SMALL = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] msg_length;
      logic [7:0] data_byte;
      logic [5:0] capacity;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic [5:0] out_length;
      logic       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       hdr_wr;
      logic       hdr_rd;
      logic       hdr_first;
      logic       hdr_done;
      logic       byte_wr;
      logic       pay_rd;
      logic       emit;
      logic [2:0] status;
      logic       with_len;
      logic       with_byte;
      logic       last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       write_open;
      logic       space_ok;
      logic       hdr_avail;
      logic       len_reject;
      logic       payload_short;
      logic       len_zero;
      logic [5:0] len_low;
   } stat_type;

endpackage

### hw/rtl/lpmf_ctrl.sv
module lpmf_ctrl #(
   parameter int HEADER_BYTES = lpmf_pkg::DEFAULT_HEADER_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         op,
   input  lpmf_pkg::stat_type stat,
   output lpmf_pkg::cmd_type  cmd,
   output logic               busy
);

   localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam logic [HCW-1:0] HDR_LAST = HCW'(HEADER_BYTES - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_HDR_WR  = 3'd1;
   localparam logic [2:0] S_HDR_RD  = 3'd2;
   localparam logic [2:0] S_CHECK   = 3'd3;
   localparam logic [2:0] S_PAYLOAD = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [HCW-1:0] cnt_ff, cnt_in;
   logic [5:0]     rem_ff, rem_in;

   assign busy = (state_ff != S_IDLE);

   // Sequence one item per visit to idle.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      cmd      = '0;
      cmd.status = lpmf_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               case (op)
                  lpmf_pkg::OP_WRITE_BEGIN: begin
                     cmd.latch = 1'b1;
                     if (stat.write_open) begin
                        cmd.emit   = 1'b1;
                        cmd.status = lpmf_pkg::ST_BUSY;
                        cmd.last   = 1'b1;
                     end else if (!stat.space_ok) begin
                        cmd.emit   = 1'b1;
                        cmd.status = lpmf_pkg::ST_FULL;
                        cmd.last   = 1'b1;
                     end else begin
                        state_in = S_HDR_WR;
                     end
                  end
                  lpmf_pkg::OP_WRITE_BYTE: begin
                     cmd.byte_wr = stat.write_open;
                  end
                  lpmf_pkg::OP_READ: begin
                     cmd.latch = 1'b1;
                     if (!stat.hdr_avail) begin
                        cmd.emit   = 1'b1;
                        cmd.status = lpmf_pkg::ST_EMPTY;
                        cmd.last   = 1'b1;
                     end else begin
                        state_in = S_HDR_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HDR_WR: begin
            cmd.hdr_wr    = 1'b1;
            cmd.hdr_first = (cnt_ff == '0);
            if (cnt_ff == HDR_LAST) begin
               cmd.hdr_done = 1'b1;
               cmd.emit     = 1'b1;
               cmd.last     = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cnt_in = cnt_ff + HCW'(1);
            end
         end
         S_HDR_RD: begin
            cmd.hdr_rd    = 1'b1;
            cmd.hdr_first = (cnt_ff == '0);
            if (cnt_ff == HDR_LAST) begin
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff + HCW'(1);
            end
         end
         S_CHECK: begin
            cmd.with_len = 1'b1;
            cmd.last     = 1'b1;
            if (stat.len_reject) begin
               cmd.emit   = 1'b1;
               cmd.status = lpmf_pkg::ST_TOO_SMALL;
               state_in   = S_IDLE;
            end else if (stat.payload_short) begin
               cmd.emit   = 1'b1;
               cmd.status = lpmf_pkg::ST_EMPTY;
               state_in   = S_IDLE;
            end else if (stat.len_zero) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.last = 1'b0;
               rem_in   = stat.len_low;
               state_in = S_PAYLOAD;
            end
         end
         S_PAYLOAD: begin
            cmd.pay_rd    = 1'b1;
            cmd.emit      = 1'b1;
            cmd.with_len  = 1'b1;
            cmd.with_byte = 1'b1;
            cmd.last      = (rem_ff == 6'd1);
            rem_in        = rem_ff - 6'd1;
            if (rem_ff == 6'd1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

### hw/rtl/lpmf_datapath.sv
module lpmf_datapath #(
   parameter int DEPTH        = lpmf_pkg::DEFAULT_DEPTH,
   parameter int HEADER_BYTES = lpmf_pkg::DEFAULT_HEADER_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  lpmf_pkg::req_type  req,
   input  lpmf_pkg::cmd_type  cmd,
   output lpmf_pkg::stat_type stat,
   output logic               rsp_valid,
   output lpmf_pkg::rsp_type  rsp
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = ((PW > 7) ? PW : 7) + 1;

   function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;

   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] cwp_ff, cwp_in;
   logic [PW-1:0] pwp_ff, pwp_in;
   logic [5:0]    due_ff, due_in;
   logic          open_ff, open_in;
   logic [5:0]    mlen_ff, cap_ff;
   logic [5:0]    len_low_ff;
   logic          big_ff;
   logic          rsp_valid_ff;
   lpmf_pkg::rsp_type rsp_ff, rsp_in;

   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [PW:0]   stored;
   logic [CW-1:0] free_space, need_space, stored_x;

   // Count committed bytes between read and write pointers.
   always_comb begin
      if (cwp_ff >= rp_ff) begin
         stored = {1'b0, cwp_ff} - {1'b0, rp_ff};
      end else begin
         stored = (PW+1)'(DEPTH) - {1'b0, rp_ff} + {1'b0, cwp_ff};
      end
      stored_x   = CW'(stored);
      free_space = CW'(DEPTH - 1) - stored_x;
      need_space = CW'(HEADER_BYTES) + CW'(req.msg_length);
   end

   always_comb begin
      stat.write_open    = open_ff;
      stat.space_ok      = (free_space >= need_space);
      stat.hdr_avail     = (stored_x >= CW'(HEADER_BYTES));
      stat.len_reject    = big_ff || (len_low_ff > cap_ff) ||
                           (len_low_ff > lpmf_pkg::MAX_PAYLOAD);
      stat.payload_short = (stored_x < CW'(len_low_ff));
      stat.len_zero      = (len_low_ff == 6'd0);
      stat.len_low       = len_low_ff;
   end

   // Write port: header bytes and payload bytes share the pending pointer.
   assign mem_we    = cmd.hdr_wr || cmd.byte_wr;
   assign mem_wdata = cmd.hdr_wr ? (cmd.hdr_first ? {2'b00, mlen_ff} : 8'h00)
                                 : req.data_byte;

   // Advance pointers, commit writes.
   always_comb begin
      rp_in   = rp_ff;
      cwp_in  = cwp_ff;
      pwp_in  = pwp_ff;
      due_in  = due_ff;
      open_in = open_ff;
      if (mem_we) begin
         pwp_in = adv(pwp_ff);
      end
      if (cmd.hdr_done) begin
         due_in = mlen_ff;
         if (mlen_ff == 6'd0) begin
            cwp_in = adv(pwp_ff);
         end else begin
            open_in = 1'b1;
         end
      end
      if (cmd.byte_wr) begin
         due_in = due_ff - 6'd1;
         if (due_ff == 6'd1) begin
            cwp_in  = adv(pwp_ff);
            open_in = 1'b0;
         end
      end
      if (cmd.hdr_rd || cmd.pay_rd) begin
         rp_in = adv(rp_ff);
      end
   end

   // Build the result beat.
   always_comb begin
      rsp_in.status     = cmd.status;
      rsp_in.out_byte   = cmd.with_byte ? rd_data_ff : 8'h00;
      rsp_in.out_length = cmd.with_len ? len_low_ff : 6'd0;
      rsp_in.last       = cmd.last;
   end

   // Byte store; keep the byte at the read pointer prefetched.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pwp_ff] <= mem_wdata;
      end
      if (mem_we && (pwp_ff == rp_in)) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= mem[rp_in];
      end
   end

   // Item fields, header length and result beat.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mlen_ff <= req.msg_length;
         cap_ff  <= req.capacity;
      end
      if (cmd.hdr_rd) begin
         if (cmd.hdr_first) begin
            len_low_ff <= rd_data_ff[5:0];
            big_ff     <= |rd_data_ff[7:6];
         end else begin
            big_ff <= big_ff || (|rd_data_ff);
         end
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         cwp_ff       <= '0;
         pwp_ff       <= '0;
         due_ff       <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         cwp_ff       <= cwp_in;
         pwp_ff       <= pwp_in;
         due_ff       <= due_in;
         open_ff      <= open_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hw/rtl/length_prefixed_message_fifo_core.sv
// Write byte: taken back to back, no result beat.
// Write begin: one header byte per store write, then a registered result beat; busy/full
//   answers come straight from idle. Read: header bytes, a length check, then the payload,
//   one byte per cycle from the store's single read port.
// Result beats are strobed for one cycle each; the receiver cannot stall them.
// Synchronous reset empties the ring and closes any open write; the store is not cleared.
`include "length_prefixed_message_fifo_core_defines.svh"

module length_prefixed_message_fifo_core #(
   parameter int DEPTH        = lpmf_pkg::DEFAULT_DEPTH,
   parameter int HEADER_BYTES = lpmf_pkg::DEFAULT_HEADER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lpmf_pkg::req_type req_payload,
   output logic              rsp_valid,
   output lpmf_pkg::rsp_type rsp_payload
);

   lpmf_pkg::cmd_type  cmd;
   lpmf_pkg::stat_type stat;

   logic rsp_err;
   logic rsp_more;
   logic wbyte_taken;

   lpmf_ctrl #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .op   (req_payload.op),
      .stat (stat),
      .cmd  (cmd),
      .busy (busy)
   );

   lpmf_datapath #(
      .DEPTH       (DEPTH),
      .HEADER_BYTES(HEADER_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_payload),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_payload)
   );

   // Qualify result beats and accepted write bytes for the checks below.
   assign rsp_err     = rsp_valid && (rsp_payload.status != lpmf_pkg::ST_OK);
   assign rsp_more    = rsp_valid && !rsp_payload.last;
   assign wbyte_taken = start && !busy && (req_payload.op == lpmf_pkg::OP_WRITE_BYTE);

   // Every error answer ends its item.
   `LPMF_ASSERT_IMPLY(a_err_last, clock, reset, rsp_err, rsp_payload.last, "error not last")
   // A payload byte that is not last is followed by another beat.
   `LPMF_ASSERT_NEXT(a_pay_run, clock, reset, rsp_more, rsp_valid, "gap inside payload run")
   // A write byte never yields a result.
   `LPMF_ASSERT_NEXT(a_wbyte_quiet, clock, reset, wbyte_taken, !rsp_valid, "write byte answered")
   // A header is only written with no write open.
   `LPMF_ASSERT_IMPLY(a_hdr_closed, clock, reset, cmd.hdr_wr, !stat.write_open, "header overlap")

endmodule

### dv/tb_length_prefixed_message_fifo_core.sv
module tb_length_prefixed_message_fifo_core;
   import lpmf_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int HDR         = DEFAULT_HEADER_BYTES;
   localparam int RING_ROOM   = DEPTH - 1;
   localparam int ITEMS       = 320;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 80;
   localparam int DRAIN_EVERY = 80;
   localparam int REQ_W       = $bits(req_type);
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // One line of the directed table; pinned lines carry their single expected beat
   typedef struct packed {
      logic [1:0] op;
      logic [5:0] mlen;
      logic [7:0] data;
      logic [5:0] cap;
      logic [5:0] reps;
      logic       ramp;
      logic       pin;
      logic [2:0] st;
      logic [5:0] len;
   } stim_row;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   // Typed-in expectation that travels with the current beat
   logic    pin_valid = 1'b0;
   rsp_type pin_beat  = '0;

   // Shadow of the ring, updated on every accepted beat
   logic [7:0] ring_bytes [DEPTH];
   int         ring_rd   = 0;
   int         ring_wr   = 0;
   int         ring_pend = 0;
   int         ring_due  = 0;
   bit         ring_open = 1'b0;
   rsp_type    awaited_beats [$];

   // Stimulus-side view of committed messages, used to shape well-formed traffic
   int queued_len  [$];
   bit queued_zero [$];
   int queued_bytes = 0;
   int sent         = 0;

   int mismatches  = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit burst_on    = 1'b0;

   stim_row directed_rows [26] = '{
      '{OP_READ,        6'd0,  8'h00, 6'd63, 6'd1,  1'b0, 1'b1, ST_EMPTY,     6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'hFF, 6'd0,  6'd1,  1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_UNUSED,      6'd63, 8'hFF, 6'd63, 6'd1,  1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_WRITE_BEGIN, 6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_WRITE_BEGIN, 6'd63, 8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_FULL,      6'd0},
      '{OP_WRITE_BEGIN, 6'd55, 8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_WRITE_BEGIN, 6'd1,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_BUSY,      6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd63, 6'd1,  1'b0, 1'b1, ST_EMPTY,     6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'hC9, 6'd0,  6'd55, 1'b1, 1'b0, ST_OK,        6'd0},
      '{OP_WRITE_BEGIN, 6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_FULL,      6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd55, 6'd1,  1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_WRITE_BEGIN, 6'd16, 8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'h00, 6'd0,  6'd16, 1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd15, 6'd1,  1'b0, 1'b1, ST_TOO_SMALL, 6'd16},
      '{OP_READ,        6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_EMPTY,     6'd0},
      '{OP_WRITE_BEGIN, 6'd8,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'd30, 6'd0,  6'd1,  1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'h00, 6'd0,  6'd7,  1'b0, 1'b0, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd7,  6'd1,  1'b0, 1'b1, ST_TOO_SMALL, 6'd8},
      '{OP_READ,        6'd0,  8'h00, 6'd63, 6'd1,  1'b0, 1'b1, ST_EMPTY,     6'd30},
      '{OP_WRITE_BEGIN, 6'd3,  8'h00, 6'd0,  6'd1,  1'b0, 1'b1, ST_OK,        6'd0},
      '{OP_WRITE_BYTE,  6'd0,  8'h5A, 6'd0,  6'd3,  1'b1, 1'b0, ST_OK,        6'd0},
      '{OP_READ,        6'd0,  8'h00, 6'd3,  6'd1,  1'b0, 1'b0, ST_OK,        6'd0}
   };

   length_prefixed_message_fifo_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type mk_beat(logic [2:0] st, logic [7:0] b, logic [5:0] len,
                                       logic fin);
      rsp_type t;
      t.status     = st;
      t.out_byte   = b;
      t.out_length = len;
      t.last       = fin;
      return t;
   endfunction

   function automatic int ring_fill();
      return (ring_wr >= ring_rd) ? ring_wr - ring_rd : DEPTH - ring_rd + ring_wr;
   endfunction

   function automatic int ring_next(int p);
      return (p + 1) % DEPTH;
   endfunction

   // Advance the shadow ring by one accepted beat and queue the beats it should produce
   function automatic void apply_to_ring(req_type item);
      logic [63:0] hdr_len;
      int          n;
      int          p;
      case (item.op)
         OP_WRITE_BEGIN: begin
            if (ring_open) begin
               awaited_beats.push_back(mk_beat(ST_BUSY, 8'd0, 6'd0, 1'b1));
            end else if (RING_ROOM - ring_fill() < HDR + int'(item.msg_length)) begin
               awaited_beats.push_back(mk_beat(ST_FULL, 8'd0, 6'd0, 1'b1));
            end else begin
               // store the little-endian header at the committed pointer
               p = ring_wr;
               for (int i = 0; i < HDR; i++) begin
                  ring_bytes[p] = 8'(64'(item.msg_length) >> (8 * i));
                  p = ring_next(p);
               end
               ring_pend = p;
               ring_due  = item.msg_length;
               if (item.msg_length == 6'd0) ring_wr = p;
               else ring_open = 1'b1;
               awaited_beats.push_back(mk_beat(ST_OK, 8'd0, 6'd0, 1'b1));
            end
         end
         OP_WRITE_BYTE: begin
            // drop stray bytes; commit on the last one due
            if (ring_open) begin
               ring_bytes[ring_pend] = item.data_byte;
               ring_pend = ring_next(ring_pend);
               ring_due--;
               if (ring_due == 0) begin
                  ring_wr   = ring_pend;
                  ring_open = 1'b0;
               end
            end
         end
         OP_READ: begin
            if (ring_fill() < HDR) begin
               awaited_beats.push_back(mk_beat(ST_EMPTY, 8'd0, 6'd0, 1'b1));
            end else begin
               hdr_len = '0;
               for (int i = 0; i < HDR; i++) begin
                  hdr_len = hdr_len | (64'(ring_bytes[ring_rd]) << (8 * i));
                  ring_rd = ring_next(ring_rd);
               end
               if (hdr_len > 64'(item.capacity) || hdr_len > 64'(MAX_PAYLOAD)) begin
                  awaited_beats.push_back(mk_beat(ST_TOO_SMALL, 8'd0, hdr_len[5:0], 1'b1));
               end else begin
                  n = int'(hdr_len);
                  if (ring_fill() < n) begin
                     awaited_beats.push_back(mk_beat(ST_EMPTY, 8'd0, hdr_len[5:0], 1'b1));
                  end else if (n == 0) begin
                     awaited_beats.push_back(mk_beat(ST_OK, 8'd0, 6'd0, 1'b1));
                  end else begin
                     for (int i = 0; i < n; i++) begin
                        awaited_beats.push_back(mk_beat(ST_OK, ring_bytes[ring_rd],
                                                        hdr_len[5:0], i == n - 1));
                        ring_rd = ring_next(ring_rd);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatches < 40)
         $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Check result beats, predict on accepted beats, and watch for a stall
   always @(posedge clock) begin
      rsp_type want;
      int      held;
      logic    took;
      if (!reset) begin
         took = start && !busy;
         if (rsp_valid) begin
            if (awaited_beats.size() == 0) begin
               flag_mismatch("result with none awaited, status", rsp_payload.status, -1);
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.out_byte !== want.out_byte)
                  flag_mismatch("out_byte", rsp_payload.out_byte, want.out_byte);
               if (rsp_payload.out_length !== want.out_length)
                  flag_mismatch("out_length", rsp_payload.out_length, want.out_length);
               if (rsp_payload.last !== want.last)
                  flag_mismatch("last", rsp_payload.last, want.last);
            end
         end
         if (took) begin
            held = awaited_beats.size();
            apply_to_ring(req_payload);
            // swap in the typed-in beat where the table pins one
            if (pin_valid) begin
               while (awaited_beats.size() > held) void'(awaited_beats.pop_back());
               awaited_beats.push_back(pin_beat);
            end
         end
         idle_cycles = (took || rsp_valid) ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Gap before the next beat; some stretches run back to back
   function automatic int draw_gap();
      if (burst_left == 0) begin
         burst_on   = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(8, 40);
      end
      burst_left--;
      return burst_on ? 0 : int'($urandom_range(0, 12));
   endfunction

   task automatic send_beat(input req_type item, input logic pin, input rsp_type want);
      int gap;
      req_payload <= item;
      pin_valid   <= pin;
      pin_beat    <= want;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender until every awaited beat has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   task automatic read_message();
      req_type item;
      int      len;
      int      cap;
      item    = req_type'(REQ_W'($urandom));
      item.op = OP_READ;
      if (queued_len.size() == 0) begin
         cap = $urandom_range(0, 63);
      end else begin
         len = queued_len[0];
         if (queued_zero[0] && $urandom_range(0, 2) == 0) begin
            // reject it; the zero payload left behind reads as empty messages
            cap = $urandom_range(0, len - 1);
            void'(queued_len.pop_front());
            void'(queued_zero.pop_front());
            repeat (len / HDR) begin
               queued_len.push_front(0);
               queued_zero.push_front(1'b0);
            end
            queued_bytes -= HDR;
         end else begin
            cap = $urandom_range(len, 63);
            void'(queued_len.pop_front());
            void'(queued_zero.pop_front());
            queued_bytes -= HDR + len;
         end
      end
      item.capacity = 6'(cap);
      send_beat(item, 1'b0, '0);
      sent++;
   endtask

   // Beats that disturb nothing or hit a refusal: busy, full, stray, unused op, reads
   task automatic send_noise(input bit write_is_open);
      req_type item;
      item = req_type'(REQ_W'($urandom));
      case ($urandom_range(0, 3))
         0: begin
            item.op = OP_WRITE_BEGIN;
            if (!write_is_open) item.msg_length = 6'($urandom_range(56, 63));
            send_beat(item, 1'b0, '0);
            sent++;
         end
         1: begin
            item.op = OP_UNUSED;
            send_beat(item, 1'b0, '0);
         end
         2: begin
            if (write_is_open) begin
               read_message();
            end else begin
               item.op = OP_WRITE_BYTE;
               send_beat(item, 1'b0, '0);
            end
         end
         default: read_message();
      endcase
   endtask

   task automatic write_message();
      req_type item;
      int      len;
      int      pick;
      bit      zero_fill;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 12);
      else if (pick < 8) len = HDR * $urandom_range(1, 4);
      else len = $urandom_range(13, MAX_PAYLOAD);
      zero_fill = (len % HDR == 0) && (len > 0) && ($urandom_range(0, 1) == 1);
      item            = req_type'(REQ_W'($urandom));
      item.op         = OP_WRITE_BEGIN;
      item.msg_length = 6'(len);
      send_beat(item, 1'b0, '0);
      sent++;
      if (RING_ROOM - queued_bytes < HDR + len) return;
      if (len > 0) begin
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) send_noise(1'b1);
            item           = req_type'(REQ_W'($urandom));
            item.op        = OP_WRITE_BYTE;
            item.data_byte = zero_fill ? 8'h00 : 8'($urandom);
            send_beat(item, 1'b0, '0);
            sent++;
         end
      end
      queued_len.push_back(len);
      queued_zero.push_back(zero_fill);
      queued_bytes += HDR + len;
   endtask

   initial begin
      req_type item;
      stim_row row;
      int      next_drain;
      int      pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, refusals, zero lengths, misframed reads
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         for (int j = 0; j < int'(row.reps); j++) begin
            item.op         = row.op;
            item.msg_length = row.mlen;
            item.data_byte  = row.ramp ? 8'(row.data + j) : row.data;
            item.capacity   = row.cap;
            send_beat(item, row.pin, mk_beat(row.st, 8'd0, row.len, 1'b1));
            sent++;
         end
      end

      // Random traffic: mostly whole messages, some noise, periodic full drains
      next_drain = DRAIN_EVERY;
      while (sent < ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) send_noise(1'b0);
         else if (queued_len.size() > 0 && (RING_ROOM - queued_bytes < 24 || pick < 50))
            read_message();
         else write_message();
         if (sent >= next_drain) begin
            wait_drained();
            next_drain += DRAIN_EVERY;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_beats.size() != 0)
         flag_mismatch("beats never delivered", awaited_beats.size(), 0);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
